@@ hw/rtl/lsag_pkg.sv @@
// types and constants shared by the load/store address generator
// depends on nothing; imported by lsag_decode and arm_load_store_address_gen
package lsag_pkg;

    localparam int unsigned NumClasses = 11;

    typedef logic [3:0] t_cls;

    // class codes, in match priority order
    localparam t_cls CLS_IMM    = 4'd0;   // word/byte, immediate offset
    localparam t_cls CLS_REG    = 4'd1;   // word/byte, register offset
    localparam t_cls CLS_SB_REG = 4'd2;   // signed byte load, register offset
    localparam t_cls CLS_H_IMM  = 4'd3;   // halfword, immediate offset
    localparam t_cls CLS_H_REG  = 4'd4;   // halfword, register offset
    localparam t_cls CLS_SCALED = 4'd5;   // word/byte, scaled register offset
    localparam t_cls CLS_MULTI  = 4'd6;   // load/store multiple
    localparam t_cls CLS_D_IMM  = 4'd7;   // doubleword, immediate offset
    localparam t_cls CLS_D_REG  = 4'd8;   // doubleword, register offset
    localparam t_cls CLS_EX     = 4'd9;   // exclusive word/byte
    localparam t_cls CLS_EX_D   = 4'd10;  // exclusive doubleword
    localparam t_cls CLS_NONE   = 4'd11;  // nothing matched

    // shift kinds of the scaled offset
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [31:0] CLASS_MASK [NumClasses] = '{
        32'h0e000000, 32'h0e000ff0, 32'h0e500ff0, 32'h0e4000f0, 32'h0e400ff0,
        32'h0e000010, 32'h0e000000, 32'h0e5000d0, 32'h0e500fd0, 32'h0fb00fff,
        32'h0ff00fff
    };

    localparam logic [31:0] CLASS_VALUE [NumClasses] = '{
        32'h04000000, 32'h06000000, 32'h001000d0, 32'h004000b0, 32'h000000b0,
        32'h06000000, 32'h08000000, 32'h004000d0, 32'h000000d0, 32'h01900f9f,
        32'h01b00f9f
    };

    // decoded word leaving the first stage
    typedef struct packed {
        t_cls        cls;
        logic [31:0] offset;    // unsigned offset magnitude, single transfers
        logic [6:0]  list4;     // four times the register count, multiples
        logic [6:0]  bytes;
        logic        load;
        logic        sx;
        logic [3:0]  rd;
        logic [3:0]  wreg;
        logic        p;
        logic        u;
        logic        w;
    } t_dec;

endpackage

@@ hw/rtl/arm_load_store_address_gen.sv @@
// top level of the load/store address generator: three-stage pipeline
// depends on lsag_pkg and lsag_decode
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  command  | start / busy          | i_instr, i_base_value, i_index_value,
//           |                       | i_carry_flag
//  result   | o_valid (strobe)      | o_matched_class, o_access_address,
//           |                       | o_access_bytes, o_is_load, o_sign_extend,
//           |                       | o_data_reg, o_writeback_enable,
//           |                       | o_writeback_reg, o_writeback_value
//
// one word enters per clock; its result strobes once it has passed the stage 1, stage 2 and output registers
// stage 1: class match, offset shifter, register list count
// stage 2: offset sign and the base adders
// stage 3: result selection into the output registers
// busy is held low: the receiver cannot stall, so nothing ever backs up
// synchronous active-low reset clears the valid bits only
module arm_load_store_address_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_instr,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_index_value,
    input  logic        i_carry_flag,
    output logic        o_valid,
    output logic [3:0]  o_matched_class,
    output logic [31:0] o_access_address,
    output logic [6:0]  o_access_bytes,
    output logic        o_is_load,
    output logic        o_sign_extend,
    output logic [3:0]  o_data_reg,
    output logic        o_writeback_enable,
    output logic [3:0]  o_writeback_reg,
    output logic [31:0] o_writeback_value
);
    import lsag_pkg::*;

    t_dec        dec;

    // stage 1 registers
    logic        r_v1;
    t_dec        r_dec1;
    logic [31:0] r_base1;

    // stage 2 registers
    logic        r_v2;
    t_dec        r_dec2;
    logic [31:0] r_base2;
    logic [31:0] r_sum2;     // base plus signed offset
    logic [31:0] r_up2;      // base plus list size
    logic [31:0] r_dn2;      // base minus list size
    logic [31:0] r_da2;      // base minus list size plus four
    logic [31:0] r_ib2;      // base plus four

    logic [31:0] soff;
    logic [31:0] list32;

    // stage 3 next values
    logic [31:0] n_addr;
    logic        n_wen;
    logic [31:0] n_wval;
    logic        single;

    assign busy = 1'b0;

    lsag_decode u_decode (
        .i_instr       (i_instr),
        .i_index_value (i_index_value),
        .i_carry_flag  (i_carry_flag),
        .o_dec         (dec)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec1  <= dec;
        r_base1 <= i_base_value;
    end

    // stage 2: subtract the offset when u is clear
    assign soff   = r_dec1.u ? r_dec1.offset : (32'd0 - r_dec1.offset);
    assign list32 = {25'd0, r_dec1.list4};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec2  <= r_dec1;
        r_base2 <= r_base1;
        r_sum2  <= r_base1 + soff;
        r_up2   <= r_base1 + list32;
        r_dn2   <= r_base1 - list32;
        r_da2   <= r_base1 + (32'd4 - list32);
        r_ib2   <= r_base1 + 32'd4;
    end

    // stage 3: pick the address and writeback for the class
    always_comb begin
        single = (r_dec2.cls == CLS_IMM)    || (r_dec2.cls == CLS_REG)   ||
                 (r_dec2.cls == CLS_SB_REG) || (r_dec2.cls == CLS_H_IMM) ||
                 (r_dec2.cls == CLS_H_REG)  || (r_dec2.cls == CLS_SCALED) ||
                 (r_dec2.cls == CLS_D_IMM)  || (r_dec2.cls == CLS_D_REG);
        n_addr = 32'd0;
        n_wen  = 1'b0;
        n_wval = 32'd0;
        if (single) begin
            // pre-indexed uses the summed address, post-indexed the base
            n_addr = r_dec2.p ? r_sum2 : r_base2;
            n_wen  = !r_dec2.p || r_dec2.w;
            n_wval = n_wen ? r_sum2 : 32'd0;
        end else if (r_dec2.cls == CLS_MULTI) begin
            // ia, ib, da, db start addresses
            if (r_dec2.u) begin
                n_addr = r_dec2.p ? r_ib2 : r_base2;
            end else begin
                n_addr = r_dec2.p ? r_dn2 : r_da2;
            end
            n_wen  = r_dec2.w;
            n_wval = r_dec2.w ? (r_dec2.u ? r_up2 : r_dn2) : 32'd0;
        end else if ((r_dec2.cls == CLS_EX) || (r_dec2.cls == CLS_EX_D)) begin
            n_addr = r_base2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        o_matched_class    <= r_dec2.cls;
        o_access_address   <= n_addr;
        o_access_bytes     <= r_dec2.bytes;
        o_is_load          <= r_dec2.load;
        o_sign_extend      <= r_dec2.sx;
        o_data_reg         <= r_dec2.rd;
        o_writeback_enable <= n_wen;
        o_writeback_reg    <= r_dec2.wreg;
        o_writeback_value  <= n_wval;
    end

endmodule

@@ hw/rtl/lsag_decode.sv @@
// instruction class match, offset formation and register list count
// depends on lsag_pkg
module lsag_decode (
    input  logic [31:0]   i_instr,
    input  logic [31:0]   i_index_value,
    input  logic          i_carry_flag,
    output lsag_pkg::t_dec o_dec
);
    import lsag_pkg::*;

    t_cls        cls;
    logic [31:0] imm8;
    logic [31:0] shifted;
    logic [63:0] ror_pair;
    logic [4:0]  amt;
    logic [4:0]  nregs;
    logic        bsel;

    assign amt  = i_instr[11:7];
    assign bsel = i_instr[22];
    assign imm8 = {24'd0, i_instr[11:8], i_instr[3:0]};
    assign ror_pair = {i_index_value, i_index_value} >> amt;
    assign nregs = 5'($countones(i_instr[15:0]));

    // first match wins
    always_comb begin
        cls = CLS_NONE;
        for (int i = NumClasses - 1; i >= 0; i--) begin
            if ((i_instr & CLASS_MASK[i]) == CLASS_VALUE[i]) begin
                cls = t_cls'(i);
            end
        end
    end

    // scaled offset, amount zero is special for all but lsl
    always_comb begin
        case (i_instr[6:5])
            SH_LSL: shifted = i_index_value << amt;
            SH_LSR: shifted = (amt == 5'd0) ? 32'd0 : (i_index_value >> amt);
            SH_ASR: shifted = (amt == 5'd0) ? {32{i_index_value[31]}}
                                            : 32'($signed(i_index_value) >>> amt);
            SH_ROR: shifted = (amt == 5'd0) ? {i_carry_flag, i_index_value[31:1]}
                                            : ror_pair[31:0];
            default: shifted = 32'd0;
        endcase
    end

    always_comb begin
        o_dec        = '0;
        o_dec.cls    = cls;
        o_dec.p      = i_instr[24];
        o_dec.u      = i_instr[23];
        o_dec.w      = i_instr[21];
        o_dec.load   = i_instr[20];
        o_dec.list4  = {nregs, 2'b00};
        if (cls != CLS_NONE) begin
            o_dec.rd   = i_instr[15:12];
            o_dec.wreg = i_instr[19:16];
        end
        case (cls)
            CLS_IMM: begin
                o_dec.offset = {20'd0, i_instr[11:0]};
                o_dec.bytes  = bsel ? 7'd1 : 7'd4;
            end
            CLS_REG: begin
                o_dec.offset = i_index_value;
                o_dec.bytes  = bsel ? 7'd1 : 7'd4;
            end
            CLS_SB_REG: begin
                o_dec.offset = i_index_value;
                o_dec.bytes  = 7'd1;
                o_dec.load   = 1'b1;
                o_dec.sx     = 1'b1;
            end
            CLS_H_IMM: begin
                o_dec.offset = imm8;
                o_dec.bytes  = 7'd2;
            end
            CLS_H_REG: begin
                o_dec.offset = i_index_value;
                o_dec.bytes  = 7'd2;
            end
            CLS_SCALED: begin
                o_dec.offset = shifted;
                o_dec.bytes  = bsel ? 7'd1 : 7'd4;
            end
            CLS_MULTI: begin
                o_dec.bytes = {nregs, 2'b00};
                o_dec.rd    = 4'd0;
            end
            CLS_D_IMM: begin
                o_dec.offset = imm8;
                o_dec.bytes  = 7'd8;
                o_dec.load   = ~i_instr[5];
            end
            CLS_D_REG: begin
                o_dec.offset = i_index_value;
                o_dec.bytes  = 7'd8;
                o_dec.load   = ~i_instr[5];
            end
            CLS_EX: begin
                o_dec.bytes = bsel ? 7'd1 : 7'd4;
                o_dec.load  = 1'b1;
            end
            CLS_EX_D: begin
                o_dec.bytes = 7'd8;
                o_dec.load  = 1'b1;
            end
            default: begin
                o_dec.load = 1'b0;
            end
        endcase
    end

endmodule
